/* sv/tcv_pkg.sv */
// shared types, constants and functions of the tensor container validator
package tcv_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [16:0] KRAFT_FULL = 17'h0_8000;
   localparam logic [16:0] KRAFT_CAP  = 17'h1_0000;
   localparam logic [15:0] MAGIC_MH   = 16'h484D;
   localparam logic [15:0] VERSION_01 = 16'h3130;
   localparam int          QUEUE_DEPTH = 4;

   // status codes
   localparam logic [4:0] ST_OK          = 5'd0;
   localparam logic [4:0] ST_TRUNC_HDR   = 5'd1;
   localparam logic [4:0] ST_MAGIC       = 5'd2;
   localparam logic [4:0] ST_VERSION     = 5'd3;
   localparam logic [4:0] ST_ROWS        = 5'd4;
   localparam logic [4:0] ST_SYMBOLS     = 5'd5;
   localparam logic [4:0] ST_CAP         = 5'd6;
   localparam logic [4:0] ST_RPB_ZERO    = 5'd7;
   localparam logic [4:0] ST_NBLOCKS     = 5'd8;
   localparam logic [4:0] ST_TRUNC_LEN   = 5'd9;
   localparam logic [4:0] ST_TABLE       = 5'd10;
   localparam logic [4:0] ST_TRUNC_ROFF  = 5'd11;
   localparam logic [4:0] ST_OFFSETS     = 5'd12;
   localparam logic [4:0] ST_TRUNC_BCRC  = 5'd13;
   localparam logic [4:0] ST_LENGTH      = 5'd14;
   localparam logic [4:0] ST_TENSOR_CRC  = 5'd15;
   localparam logic [4:0] ST_BLOCK_CRC   = 5'd16;

   // register indexes
   localparam logic [2:0] CSR_EXPECT_ROWS    = 3'd0;
   localparam logic [2:0] CSR_EXPECT_SYMBOLS = 3'd1;
   localparam logic [2:0] CSR_MAX_ROWS       = 3'd2;
   localparam logic [2:0] CSR_MAX_SYMBOLS    = 3'd3;
   localparam logic [2:0] CSR_MAX_BLOCKS     = 3'd4;
   localparam logic [2:0] CSR_MAX_PAYLOAD    = 3'd5;
   localparam logic [2:0] CSR_FULL_VERIFY    = 3'd6;

   typedef struct packed {
      logic [32:0] expect_rows;
      logic [32:0] expect_symbols;
      logic [31:0] max_rows;
      logic [31:0] max_symbols;
      logic [31:0] max_blocks;
      logic [31:0] max_payload;
      logic        full_verify;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [16:0] kraft;
      logic [4:0]  npres;
      logic [3:0]  maxl;
      logic [3:0]  sole;
   } len_acc_type;

   function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // one code length into the running kraft sum and table facts
   function automatic len_acc_type len_update(len_acc_type a, logic [3:0] len);
      len_acc_type r;
      logic [17:0] sum;
      r   = a;
      sum = {1'b0, a.kraft} + (18'd1 << (4'd15 - len));
      if (len != 4'd0) begin
         r.npres = a.npres + 5'd1;
         if (len > a.maxl) begin
            r.maxl = len;
         end
         if (a.npres == 5'd0) begin
            r.sole = len;
         end
         r.kraft = (sum > {1'b0, KRAFT_CAP}) ? KRAFT_CAP : sum[16:0];
      end
      return r;
   endfunction

endpackage

/* sv/tensor_container_validator.sv */
// top level of the tensor container validator: registers, byte queue and parser
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_byte, req_last_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_status .. rsp_symbols_present
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one byte per cycle, while the queue holds one, through header, length table, row offsets and block crcs;
// after the 24th byte the header check runs in S_HCHK1 (which registers the multiply) and then S_HCHK2.
// payload: each block boundary is closed in S_PAY and then waits in S_LOAD for the ram read;
// blocks left open at the end are closed in S_CLOSE, each followed by S_LOAD.
// the status transaction is registered once the last byte's work is done and rsp is not stalled.
// reset is synchronous; a four-entry queue lets input and parser stall on their own.
module tensor_container_validator
   import tcv_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_status,
   output logic [31:0] rsp_bad_block,
   output logic [31:0] rsp_rows,
   output logic [31:0] rsp_symbols,
   output logic [31:0] rsp_rows_in_block,
   output logic [31:0] rsp_payload_length,
   output logic [3:0]  rsp_max_code_len,
   output logic [4:0]  rsp_symbols_present,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [32:0] csr_data
);

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expect_rows    <= 33'h1_FFFF_FFFF;
         cfg_ff.expect_symbols <= 33'h1_FFFF_FFFF;
         cfg_ff.max_rows       <= '0;
         cfg_ff.max_symbols    <= '0;
         cfg_ff.max_blocks     <= '0;
         cfg_ff.max_payload    <= '0;
         cfg_ff.full_verify    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECT_ROWS:    cfg_ff.expect_rows    <= csr_data;
            CSR_EXPECT_SYMBOLS: cfg_ff.expect_symbols <= csr_data;
            CSR_MAX_ROWS:       cfg_ff.max_rows       <= csr_data[31:0];
            CSR_MAX_SYMBOLS:    cfg_ff.max_symbols    <= csr_data[31:0];
            CSR_MAX_BLOCKS:     cfg_ff.max_blocks     <= csr_data[31:0];
            CSR_MAX_PAYLOAD:    cfg_ff.max_payload    <= csr_data[31:0];
            CSR_FULL_VERIFY:    cfg_ff.full_verify    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   tcv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   tcv_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_bad_block       (rsp_bad_block),
      .rsp_rows            (rsp_rows),
      .rsp_symbols         (rsp_symbols),
      .rsp_rows_in_block   (rsp_rows_in_block),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_max_code_len    (rsp_max_code_len),
      .rsp_symbols_present (rsp_symbols_present)
   );

endmodule

/* sv/tcv_ram.sv */
// generic single write, single read ram with registered read data
module tcv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tcv_front.sv */
// input side: takes blob bytes and queues them for the parser
module tcv_front
   import tcv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [7:0] req_data_byte,
   input  logic     req_last_byte,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              push;

   assign req_stall = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req_data_byte, last_byte: req_last_byte};
      end
   end

endmodule

/* sv/tcv_back.sv */
// parser: walks the blob sections, checks them and issues the status transaction
module tcv_back
   import tcv_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_status,
   output logic [31:0] rsp_bad_block,
   output logic [31:0] rsp_rows,
   output logic [31:0] rsp_symbols,
   output logic [31:0] rsp_rows_in_block,
   output logic [31:0] rsp_payload_length,
   output logic [3:0]  rsp_max_code_len,
   output logic [4:0]  rsp_symbols_present
);

   localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BIW = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [3:0] {
      S_HDR, S_HCHK1, S_HCHK2, S_LEN, S_ROFF, S_BCRC, S_LOAD, S_PAY, S_CLOSE, S_END, S_SKIP
   } state_type;

   state_type   state_ff;
   logic        pend_ff;
   logic [4:0]  sec_pos_ff;
   logic [31:0] magic_ff, rows_ff, syms_ff, rpb_ff, nb_ff, tcrc_ff;
   logic [4:0]  err_ff;
   logic [63:0] prod_ff, prod_in;
   len_acc_type acc_ff;
   logic [23:0] wacc_ff;
   logic [31:0] row_ff, rib_ff, prev_ff;
   logic        obad_ff;
   logic [BIW-1:0] blk_ff, wi_ff, bad_idx_ff;
   logic [31:0] plen_ff, ppos_ff;
   logic [31:0] trun_ff, brun_ff;
   logic        bad_found_ff, closing_ff;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_status_ff;
   logic [31:0] rsp_bad_block_ff, rsp_rows_ff, rsp_symbols_ff, rsp_rpb_ff, rsp_plen_ff;
   logic [3:0]  rsp_maxl_ff;
   logic [4:0]  rsp_npres_ff;

   logic [31:0] rd_bnd, rd_crc;
   logic        bnd_we, crc_we;
   logic        takes_bytes, emit_ok, do_emit, close_need, blk_left;
   logic [7:0]  b;
   logic [1:0]  lane;
   logic [31:0] cur_word;
   logic        row_last, blk_close, bad_new;
   len_acc_type acc_lo, acc_hi;
   logic        len_bad, hdr_nb_ok;
   logic [4:0]  hdr_err, st_in;
   logic        fields_ok;

   assign b    = q_item.data_byte;
   assign lane = sec_pos_ff[1:0];

   always_comb begin
      takes_bytes = (state_ff == S_HDR) || (state_ff == S_LEN) || (state_ff == S_ROFF) ||
                    (state_ff == S_BCRC) || (state_ff == S_PAY) || (state_ff == S_END) ||
                    (state_ff == S_SKIP);
      emit_ok    = !rsp_valid_ff || !rsp_stall;
      do_emit    = takes_bytes && pend_ff && emit_ok;
      blk_left   = (32'(blk_ff) < nb_ff);
      close_need = blk_left && (rd_bnd <= ppos_ff);
      q_pop      = takes_bytes && !pend_ff && q_valid && !((state_ff == S_PAY) && close_need);

      cur_word  = {b, wacc_ff};
      row_last  = (row_ff == rows_ff);
      blk_close = (row_ff != '0) && ((rib_ff + 32'd1 == rpb_ff) || row_last);
      bad_new   = obad_ff || ((row_ff == '0) ? (cur_word != '0) : (cur_word < prev_ff));
      bnd_we    = q_pop && (state_ff == S_ROFF) && (lane == 2'd3) && blk_close &&
                  (32'(blk_ff) < 32'(MAX_BLOCKS));
      crc_we    = q_pop && (state_ff == S_BCRC) && (lane == 2'd3);

      acc_lo = len_update(acc_ff, b[3:0]);
      acc_hi = len_update(acc_lo, b[7:4]);
      if (acc_hi.npres <= 5'd1) begin
         len_bad = (acc_hi.npres == 5'd1) && (acc_hi.sole != 4'd1);
      end else begin
         len_bad = (acc_hi.kraft != KRAFT_FULL);
      end
      if ((acc_hi.npres == 5'd0) && (rows_ff != '0) && (syms_ff != '0)) begin
         len_bad = 1'b1;
      end

      prod_in = 64'(nb_ff) * 64'(rpb_ff);
      if (magic_ff[15:0] != MAGIC_MH) begin
         hdr_err = ST_MAGIC;
      end else if (magic_ff[31:16] != VERSION_01) begin
         hdr_err = ST_VERSION;
      end else if (!cfg.expect_rows[32] && (cfg.expect_rows[31:0] != rows_ff)) begin
         hdr_err = ST_ROWS;
      end else if (!cfg.expect_symbols[32] && (cfg.expect_symbols[31:0] != syms_ff)) begin
         hdr_err = ST_SYMBOLS;
      end else if (((cfg.max_rows != '0) && (rows_ff > cfg.max_rows)) ||
                   ((cfg.max_symbols != '0) && (syms_ff > cfg.max_symbols)) ||
                   ((cfg.max_blocks != '0) && (nb_ff > cfg.max_blocks)) ||
                   (nb_ff > 32'(MAX_BLOCKS))) begin
         hdr_err = ST_CAP;
      end else if ((rows_ff != '0) && (rpb_ff == '0)) begin
         hdr_err = ST_RPB_ZERO;
      end else begin
         hdr_err = ST_OK;
      end
      // nb == ceil(rows/rpb) without a divider: (nb-1)*rpb < rows <= nb*rpb
      if (rows_ff == '0) begin
         hdr_nb_ok = (nb_ff == '0);
      end else begin
         hdr_nb_ok = (prod_ff >= 64'(rows_ff)) && (prod_ff < 64'(rows_ff) + 64'(rpb_ff));
      end

      st_in = ST_OK;
      if (err_ff != ST_OK) begin
         st_in = err_ff;
      end else begin
         case (state_ff)
            S_HDR:  st_in = ST_TRUNC_HDR;
            S_LEN:  st_in = ST_TRUNC_LEN;
            S_ROFF: st_in = ST_TRUNC_ROFF;
            S_BCRC: st_in = ST_TRUNC_BCRC;
            S_PAY:  st_in = ST_LENGTH;
            S_END: begin
               if (cfg.full_verify) begin
                  if ((trun_ff ^ ALL_ONES) != tcrc_ff) begin
                     st_in = ST_TENSOR_CRC;
                  end else if (bad_found_ff) begin
                     st_in = ST_BLOCK_CRC;
                  end
               end
            end
            default: st_in = ST_OK;
         endcase
      end
      fields_ok = (st_in == ST_OK) || (st_in == ST_TENSOR_CRC) || (st_in == ST_BLOCK_CRC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_HDR;
         pend_ff      <= 1'b0;
         sec_pos_ff   <= '0;
         err_ff       <= ST_OK;
         acc_ff       <= '0;
         row_ff       <= '0;
         rib_ff       <= '0;
         prev_ff      <= '0;
         obad_ff      <= 1'b0;
         blk_ff       <= '0;
         wi_ff        <= '0;
         bad_idx_ff   <= '0;
         plen_ff      <= '0;
         ppos_ff      <= '0;
         trun_ff      <= ALL_ONES;
         brun_ff      <= ALL_ONES;
         bad_found_ff <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff     <= 1'b1;
         rsp_status_ff    <= st_in;
         rsp_bad_block_ff <= (st_in == ST_BLOCK_CRC) ? 32'(bad_idx_ff) : '0;
         rsp_rows_ff      <= fields_ok ? rows_ff : '0;
         rsp_symbols_ff   <= fields_ok ? syms_ff : '0;
         rsp_rpb_ff       <= fields_ok ? rpb_ff : '0;
         rsp_plen_ff      <= fields_ok ? plen_ff : '0;
         rsp_maxl_ff      <= fields_ok ? acc_ff.maxl : '0;
         rsp_npres_ff     <= fields_ok ? acc_ff.npres : '0;
         // fresh blob
         state_ff     <= S_HDR;
         pend_ff      <= 1'b0;
         sec_pos_ff   <= '0;
         err_ff       <= ST_OK;
         acc_ff       <= '0;
         row_ff       <= '0;
         rib_ff       <= '0;
         prev_ff      <= '0;
         obad_ff      <= 1'b0;
         blk_ff       <= '0;
         wi_ff        <= '0;
         bad_idx_ff   <= '0;
         plen_ff      <= '0;
         ppos_ff      <= '0;
         trun_ff      <= ALL_ONES;
         brun_ff      <= ALL_ONES;
         bad_found_ff <= 1'b0;
         closing_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop && q_item.last_byte) begin
            pend_ff <= 1'b1;
         end
         if (q_pop && ((state_ff == S_LEN) || (state_ff == S_ROFF) ||
                       (state_ff == S_BCRC) || (state_ff == S_PAY))) begin
            trun_ff <= crc_byte(trun_ff, b);
         end
         case (state_ff)
            S_HDR: begin
               if (q_pop) begin
                  case (sec_pos_ff[4:2])
                     3'd0:    magic_ff[8*lane +: 8] <= b;
                     3'd1:    rows_ff[8*lane +: 8]  <= b;
                     3'd2:    syms_ff[8*lane +: 8]  <= b;
                     3'd3:    rpb_ff[8*lane +: 8]   <= b;
                     3'd4:    nb_ff[8*lane +: 8]    <= b;
                     default: tcrc_ff[8*lane +: 8]  <= b;
                  endcase
                  if (sec_pos_ff == 5'd23) begin
                     state_ff <= S_HCHK1;
                  end else begin
                     sec_pos_ff <= sec_pos_ff + 5'd1;
                  end
               end
            end
            S_HCHK1: begin
               prod_ff <= prod_in;
               if (hdr_err != ST_OK) begin
                  err_ff   <= hdr_err;
                  state_ff <= S_SKIP;
               end else begin
                  state_ff <= S_HCHK2;
               end
            end
            S_HCHK2: begin
               sec_pos_ff <= '0;
               if (hdr_nb_ok) begin
                  state_ff <= S_LEN;
               end else begin
                  err_ff   <= ST_NBLOCKS;
                  state_ff <= S_SKIP;
               end
            end
            S_LEN: begin
               if (q_pop) begin
                  acc_ff <= acc_hi;
                  if (sec_pos_ff == 5'd7) begin
                     sec_pos_ff <= '0;
                     if (len_bad) begin
                        err_ff   <= ST_TABLE;
                        state_ff <= S_SKIP;
                     end else begin
                        if (acc_hi.npres <= 5'd1) begin
                           acc_ff.maxl <= 4'd1;
                        end
                        state_ff <= S_ROFF;
                     end
                  end else begin
                     sec_pos_ff <= sec_pos_ff + 5'd1;
                  end
               end
            end
            S_ROFF: begin
               if (q_pop) begin
                  if (lane != 2'd3) begin
                     wacc_ff[8*lane +: 8] <= b;
                     sec_pos_ff <= sec_pos_ff + 5'd1;
                  end else begin
                     sec_pos_ff <= '0;
                     prev_ff    <= cur_word;
                     obad_ff    <= bad_new;
                     if (row_ff != '0) begin
                        rib_ff <= blk_close ? '0 : rib_ff + 32'd1;
                        if (blk_close) begin
                           blk_ff <= blk_ff + 1'b1;
                        end
                     end
                     if (!row_last) begin
                        row_ff <= row_ff + 32'd1;
                     end else if (bad_new) begin
                        err_ff   <= ST_OFFSETS;
                        state_ff <= S_SKIP;
                     end else begin
                        plen_ff <= cur_word;
                        if ((cfg.max_payload != '0) && (cur_word > cfg.max_payload)) begin
                           err_ff   <= ST_CAP;
                           state_ff <= S_SKIP;
                        end else if (nb_ff != '0) begin
                           wi_ff    <= '0;
                           state_ff <= S_BCRC;
                        end else begin
                           ppos_ff    <= '0;
                           blk_ff     <= '0;
                           brun_ff    <= ALL_ONES;
                           closing_ff <= (cur_word == '0);
                           state_ff   <= S_LOAD;
                        end
                     end
                  end
               end
            end
            S_BCRC: begin
               if (q_pop) begin
                  if (lane != 2'd3) begin
                     wacc_ff[8*lane +: 8] <= b;
                     sec_pos_ff <= sec_pos_ff + 5'd1;
                  end else begin
                     sec_pos_ff <= '0;
                     if (33'(wi_ff) + 33'd1 == 33'(nb_ff)) begin
                        ppos_ff    <= '0;
                        blk_ff     <= '0;
                        brun_ff    <= ALL_ONES;
                        closing_ff <= (plen_ff == '0);
                        state_ff   <= S_LOAD;
                     end else begin
                        wi_ff <= wi_ff + 1'b1;
                     end
                  end
               end
            end
            S_LOAD: begin
               // ram read of the current block entries is registered here for S_PAY or S_CLOSE
               state_ff <= closing_ff ? S_CLOSE : S_PAY;
            end
            S_PAY: begin
               if (!pend_ff && close_need) begin
                  if (!bad_found_ff && ((brun_ff ^ ALL_ONES) != rd_crc)) begin
                     bad_found_ff <= 1'b1;
                     bad_idx_ff   <= blk_ff;
                  end
                  brun_ff  <= ALL_ONES;
                  blk_ff   <= blk_ff + 1'b1;
                  state_ff <= S_LOAD;
               end else if (q_pop) begin
                  brun_ff <= crc_byte(brun_ff, b);
                  ppos_ff <= ppos_ff + 32'd1;
                  if (33'(ppos_ff) + 33'd1 == 33'(plen_ff)) begin
                     closing_ff <= 1'b1;
                     state_ff   <= S_CLOSE;
                  end
               end
            end
            S_CLOSE: begin
               if (blk_left) begin
                  if (!bad_found_ff && ((brun_ff ^ ALL_ONES) != rd_crc)) begin
                     bad_found_ff <= 1'b1;
                     bad_idx_ff   <= blk_ff;
                  end
                  brun_ff  <= ALL_ONES;
                  blk_ff   <= blk_ff + 1'b1;
                  state_ff <= S_LOAD;
               end else begin
                  closing_ff <= 1'b0;
                  state_ff   <= S_END;
               end
            end
            S_END: begin
               if (q_pop) begin
                  err_ff   <= ST_LENGTH;
                  state_ff <= S_SKIP;
               end
            end
            default: begin
               // error seen: absorb bytes until the last one
            end
         endcase
      end
   end

   tcv_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (blk_ff[AW-1:0]),
      .wr_data (cur_word),
      .rd_addr (blk_ff[AW-1:0]),
      .rd_data (rd_bnd)
   );

   tcv_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_crc_ram (
      .clock   (clock),
      .wr_en   (crc_we),
      .wr_addr (wi_ff[AW-1:0]),
      .wr_data (cur_word),
      .rd_addr (blk_ff[AW-1:0]),
      .rd_data (rd_crc)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bad_block       = rsp_bad_block_ff;
   assign rsp_rows            = rsp_rows_ff;
   assign rsp_symbols         = rsp_symbols_ff;
   assign rsp_rows_in_block   = rsp_rpb_ff;
   assign rsp_payload_length  = rsp_plen_ff;
   assign rsp_max_code_len    = rsp_maxl_ff;
   assign rsp_symbols_present = rsp_npres_ff;

endmodule

/* sv/tcv_checker.sv */
// port-level checks on the validator's status transactions, bound to the top level
module tcv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_status,
   input logic [31:0] rsp_bad_block,
   input logic [31:0] rsp_rows,
   input logic [31:0] rsp_payload_length,
   input logic [3:0]  rsp_max_code_len
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("status changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 5'd16)
      else $error("status code out of range");

   a_bad_block_only_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 5'd16 |-> rsp_bad_block == 32'd0)
      else $error("bad block reported without block crc error");

   a_struct_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 5'd0 && rsp_status != 5'd15 && rsp_status != 5'd16
      |-> rsp_rows == 32'd0 && rsp_payload_length == 32'd0 && rsp_max_code_len == 4'd0)
      else $error("fields not cleared on structural error");

   a_maxlen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == 5'd0 || rsp_status == 5'd15 || rsp_status == 5'd16)
      |-> rsp_max_code_len != 4'd0)
      else $error("max code length zero on a parsed blob");

endmodule

bind tensor_container_validator tcv_checker u_tcv_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_bad_block      (rsp_bad_block),
   .rsp_rows           (rsp_rows),
   .rsp_payload_length (rsp_payload_length),
   .rsp_max_code_len   (rsp_max_code_len)
);
